>>> rtl/cict_pkg.sv
package cict_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int VAL_W          = 16;
  localparam int Q_W            = 16;
  localparam int WEIGHT_STEPS   = 256;
  localparam int WS_BITS        = $clog2(WEIGHT_STEPS);
  localparam int PT_W           = 2 * VAL_W;
  localparam int ACC_W          = 31;

  localparam logic [VAL_W-1:0] ONE_Q15 = 16'h8000;

  // pi in Q2.62 and the angle step pi / (2 * steps)
  localparam logic [63:0] PI_Q62 = 64'd14488038916154245684;
  localparam logic [63:0] H_STEP = PI_Q62 / (2 * WEIGHT_STEPS);

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DELETE,
    OP_EVALUATE,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_BAD_INDEX,
    ST_NO_BRACKET
  } status_t;

  typedef enum logic [3:0] {
    S_INIT_LO,
    S_INIT_HI,
    S_IDLE,
    S_DEL_RD,
    S_DEL_WR,
    S_SCAN,
    S_DIV,
    S_WEIGHT,
    S_MUL_HI,
    S_MUL_LO,
    S_DONE
  } state_t;

  typedef logic [VAL_W-1:0] weight_rom_t [WEIGHT_STEPS];

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // taylor term divisor (2n)(2n+1); terms are zero long before the last arm
  function automatic logic [63:0] taylor_div(logic [63:0] term, int unsigned n);
    case (n)
      1:       return term / 64'd6;
      2:       return term / 64'd20;
      3:       return term / 64'd42;
      4:       return term / 64'd72;
      5:       return term / 64'd110;
      6:       return term / 64'd156;
      7:       return term / 64'd210;
      8:       return term / 64'd272;
      9:       return term / 64'd342;
      10:      return term / 64'd420;
      11:      return term / 64'd506;
      12:      return term / 64'd600;
      13:      return term / 64'd702;
      14:      return term / 64'd812;
      15:      return term / 64'd930;
      16:      return term / 64'd1056;
      17:      return term / 64'd1190;
      18:      return term / 64'd1332;
      19:      return term / 64'd1482;
      20:      return term / 64'd1640;
      default: return 64'd0;
    endcase
  endfunction

  // round(32768 * sin^2(pi*k/(2*steps)))
  function automatic logic [VAL_W-1:0] cos_weight(int unsigned k);
    logic [63:0]  h;
    logic [63:0]  h2;
    logic [63:0]  term;
    logic [63:0]  s;
    logic [63:0]  r;
    logic [127:0] p;
    int unsigned  n;
    h    = H_STEP * 64'(k);
    h2   = mul_q62(h, h);
    term = h;
    s    = h;
    for (n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        term = taylor_div(mul_q62(term, h2), n);
        if ((n % 2) == 1) s = s - term;
        else              s = s + term;
      end
    end
    p = {64'd0, s} * {64'd0, s};
    r = (p[127:64] + (64'd1 << 44)) >> 45;
    return r[VAL_W-1:0];
  endfunction

  function automatic weight_rom_t build_weight_rom();
    weight_rom_t rom;
    int unsigned k;
    for (k = 0; k < WEIGHT_STEPS; k++) rom[k] = cos_weight(k);
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

endpackage

>>> rtl/cict_ram.sv
module cict_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/cosine_interpolated_curve_table.sv
// flow: add, bad-index delete and unused op go from accept straight to the done state;
// delete reads and rewrites each entry above the index; evaluate scans one entry per cycle,
// then unless it matched or lacks a bracket: 16-step divide, rom read, two multiplies
// throughput: one word at a time, in_tready only while the sequencer is idle
// reset: synchronous, active low; after release the init states write the default end
// points, during which no word is accepted; a waiting result is dropped by reset
module cosine_interpolated_curve_table
  import cict_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // x_value[15:0], y_value[31:16], entry_index[35:32], zero
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // curve_value[15:0], status[17:16], point_count[22:18], zero
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int DC_W  = $clog2(Q_W);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VAL_W-1:0]   q_r, q_nxt;
  logic [IDX_W-1:0]   del_j_r, del_j_nxt;
  logic [CNT_W-1:0]   scan_addr_r, scan_addr_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               match_r, match_nxt;
  logic               lo_ok_r, lo_ok_nxt;
  logic               hi_ok_r, hi_ok_nxt;
  logic [VAL_W-1:0]   match_y_r, match_y_nxt;
  logic [VAL_W-1:0]   lo_x_r, lo_x_nxt, lo_y_r, lo_y_nxt;
  logic [VAL_W-1:0]   hi_x_r, hi_x_nxt, hi_y_r, hi_y_nxt;
  logic [Q_W:0]       rem_r, rem_nxt;
  logic [VAL_W-1:0]   den_r, den_nxt;
  logic [Q_W-1:0]     quot_r, quot_nxt;
  logic [DC_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic [VAL_W-1:0]   w_r, w_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [VAL_W-1:0]   res_value_r, res_value_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [4:0]         out_count_r, out_count_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [PT_W-1:0]    ram_wdata, ram_rdata;

  logic               in_accept;
  op_t                in_op;
  logic [VAL_W-1:0]   in_x, in_y;
  logic [3:0]         in_idx;
  logic [VAL_W-1:0]   x_sat, y_sat;
  logic               table_full, idx_bad, del_more, scan_done, no_div;
  logic [CNT_W-1:0]   del_next;
  logic [VAL_W-1:0]   rd_x, rd_y;
  logic [Q_W:0]       rem_sh;
  logic [VAL_W-1:0]   mul_a, mul_b;
  logic [PT_W-1:0]    mul_p;
  logic [ACC_W-1:0]   blend_sum;

  assign in_op   = op_t'(in_tuser);
  assign in_x    = in_tdata[15:0];
  assign in_y    = in_tdata[31:16];
  assign in_idx  = in_tdata[35:32];
  assign x_sat   = (in_x > ONE_Q15) ? ONE_Q15 : in_x;
  assign y_sat   = (in_y > ONE_Q15) ? ONE_Q15 : in_y;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign table_full = (cnt_r >= CNT_W'(MAX_POINTS));
  assign idx_bad    = (CMP_W'(in_idx) >= CMP_W'(cnt_r));
  assign del_next   = CNT_W'(del_j_r) + CNT_W'(1);
  assign del_more   = (del_next < cnt_r);
  assign scan_done  = (scan_addr_r >= cnt_r) && !rd_pend_r;
  assign no_div     = match_r || !lo_ok_r || !hi_ok_r;

  assign rd_x = ram_rdata[VAL_W-1:0];
  assign rd_y = ram_rdata[PT_W-1:VAL_W];

  assign rem_sh = {rem_r[Q_W-1:0], 1'b0};

  // shared multiplier: weight times upper y, then complement times lower y
  assign mul_a     = (state_r == S_MUL_HI) ? w_r : VAL_W'(ONE_Q15 - w_r);
  assign mul_b     = (state_r == S_MUL_HI) ? hi_y_r : lo_y_r;
  assign mul_p     = mul_a * mul_b;
  assign blend_sum = acc_r + ACC_W'(mul_p);

  cict_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT_LO: state_nxt = S_INIT_HI;
      S_INIT_HI: state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_DELETE:   state_nxt = idx_bad ? S_DONE : S_DEL_RD;
            OP_EVALUATE: state_nxt = S_SCAN;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_DEL_RD:  state_nxt = del_more ? S_DEL_WR : S_DONE;
      S_DEL_WR:  state_nxt = S_DEL_RD;
      S_SCAN: begin
        if (scan_done) state_nxt = no_div ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (div_cnt_r == DC_W'(Q_W - 1)) state_nxt = S_WEIGHT;
      end
      S_WEIGHT:  state_nxt = S_MUL_HI;
      S_MUL_HI:  state_nxt = S_MUL_LO;
      S_MUL_LO:  state_nxt = S_DONE;
      S_DONE: begin
        if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    q_nxt          = q_r;
    del_j_nxt      = del_j_r;
    scan_addr_nxt  = scan_addr_r;
    rd_pend_nxt    = 1'b0;
    match_nxt      = match_r;
    lo_ok_nxt      = lo_ok_r;
    hi_ok_nxt      = hi_ok_r;
    match_y_nxt    = match_y_r;
    lo_x_nxt       = lo_x_r;
    lo_y_nxt       = lo_y_r;
    hi_x_nxt       = hi_x_r;
    hi_y_nxt       = hi_y_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    quot_nxt       = quot_r;
    div_cnt_nxt    = div_cnt_r;
    w_nxt          = w_r;
    acc_nxt        = acc_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = del_j_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = IDX_W'(del_next);

    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;

    case (state_r)
      S_INIT_LO: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
      end
      S_INIT_HI: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(1);
        ram_wdata = {ONE_Q15, ONE_Q15};
      end
      S_IDLE: begin
        if (in_accept) begin
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          case (in_op)
            OP_ADD: begin
              if (table_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(cnt_r);
                ram_wdata = {y_sat, x_sat};
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (idx_bad) res_status_nxt = ST_BAD_INDEX;
              del_j_nxt = IDX_W'(in_idx);
            end
            OP_EVALUATE: begin
              q_nxt         = x_sat;
              scan_addr_nxt = '0;
              match_nxt     = 1'b0;
              lo_ok_nxt     = 1'b0;
              hi_ok_nxt     = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_DEL_RD: begin
        if (!del_more) cnt_nxt = cnt_r - CNT_W'(1);
      end
      S_DEL_WR: begin
        // entry j+1 was read last cycle, move it down one place
        ram_we    = 1'b1;
        del_j_nxt = del_j_r + IDX_W'(1);
      end
      S_SCAN: begin
        ram_raddr = IDX_W'(scan_addr_r);
        if (scan_addr_r < cnt_r) begin
          scan_addr_nxt = scan_addr_r + CNT_W'(1);
          rd_pend_nxt   = 1'b1;
        end
        if (rd_pend_r) begin
          if (rd_x == q_r && !match_r) begin
            match_nxt   = 1'b1;
            match_y_nxt = rd_y;
          end
          if (rd_x < q_r && (!lo_ok_r || rd_x > lo_x_r)) begin
            lo_ok_nxt = 1'b1;
            lo_x_nxt  = rd_x;
            lo_y_nxt  = rd_y;
          end
          if (rd_x > q_r && (!hi_ok_r || rd_x < hi_x_r)) begin
            hi_ok_nxt = 1'b1;
            hi_x_nxt  = rd_x;
            hi_y_nxt  = rd_y;
          end
        end
        if (scan_done) begin
          if (match_r) begin
            res_value_nxt = match_y_r;
          end else if (!lo_ok_r || !hi_ok_r) begin
            res_status_nxt = ST_NO_BRACKET;
          end else begin
            rem_nxt     = (Q_W+1)'(q_r - lo_x_r);
            den_nxt     = hi_x_r - lo_x_r;
            quot_nxt    = '0;
            div_cnt_nxt = '0;
          end
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt  = rem_sh - {1'b0, den_r};
          quot_nxt = {quot_r[Q_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          quot_nxt = {quot_r[Q_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + DC_W'(1);
      end
      S_WEIGHT: begin
        w_nxt = WEIGHT_ROM[quot_r[Q_W-1 -: WS_BITS]];
      end
      S_MUL_HI: begin
        acc_nxt = ACC_W'(mul_p);
      end
      S_MUL_LO: begin
        res_value_nxt = blend_sum[ACC_W-1 -: VAL_W];
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = 5'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT_LO;
      cnt_r        <= CNT_W'(2);
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    del_j_r      <= del_j_nxt;
    scan_addr_r  <= scan_addr_nxt;
    match_r      <= match_nxt;
    lo_ok_r      <= lo_ok_nxt;
    hi_ok_r      <= hi_ok_nxt;
    match_y_r    <= match_y_nxt;
    lo_x_r       <= lo_x_nxt;
    lo_y_r       <= lo_y_nxt;
    hi_x_r       <= hi_x_nxt;
    hi_y_r       <= hi_y_nxt;
    rem_r        <= rem_nxt;
    den_r        <= den_nxt;
    quot_r       <= quot_nxt;
    div_cnt_r    <= div_cnt_nxt;
    w_r          <= w_nxt;
    acc_r        <= acc_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_count_r, out_status_r, out_value_r};

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("point count above table depth");

  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_status_r != ST_OK |-> out_value_r == '0)
    else $error("error result carries a curve value");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_op == OP_ADD && !table_full |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("add did not grow the table");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < {1'b0, den_r})
    else $error("divider remainder not below divisor");

endmodule
